FILE: rtl/eia2_pkg.sv
// Shared types, constants and AES helper functions for the EIA2 tag block.
package eia2_pkg;

	localparam int WordBits = 64;
	localparam logic [7:0] CmacRb = 8'h87;

	localparam logic [2:0] RegKeyHigh = 3'd0;
	localparam logic [2:0] RegKeyLow = 3'd1;
	localparam logic [2:0] RegCount = 3'd2;
	localparam logic [2:0] RegBearer = 3'd3;
	localparam logic [2:0] RegDir = 3'd4;

	// One queued item from the front end to the back end.
	typedef struct packed {
		logic [63:0] word;
		logic [6:0]  nbits;
		logic        last;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUBKEY,
		ST_ABSORB,
		ST_FINAL,
		ST_OUT
	} state_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a block sits at bits [127-8i -: 8].
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
			input logic is_last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, x;
		logic [127:0] o;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[c*4+i] = sbox(s[127-8*(((c+i)%4)*4+i) -: 8]);
		if (!is_last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
				x = a0 ^ a1 ^ a2 ^ a3;
				t[c*4]   = a0 ^ x ^ xtime(a0 ^ a1);
				t[c*4+1] = a1 ^ x ^ xtime(a1 ^ a2);
				t[c*4+2] = a2 ^ x ^ xtime(a2 ^ a3);
				t[c*4+3] = a3 ^ x ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++)
			o[127-8*i -: 8] = t[i];
		return o ^ rk;
	endfunction

	function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, g;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		g = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ g; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [127:0] dbl(input logic [127:0] v);
		return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? CmacRb : 8'h00)};
	endfunction

endpackage

FILE: rtl/eps_integrity_cmac_tag.sv
// Top level of the 128-EIA2 (AES-128 CMAC) integrity tag engine.
// Usage: write key_high, key_low, msg_count, bearer_id and link_direction through the
// configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while idle. Then
// send message words on the input channel (valid/stall, data_word, valid_bits,
// last_word), first bit in the most significant position. The first word of each
// message loads the header registers and derives the subkeys with one AES pass. Each
// 128-bit block takes one such pass. The last word starts the final encryption when
// the back end takes it; its tag appears on mac with out_valid when that pass ends
// and holds while out_stall is high. While a tag waits, the back end keeps working
// on the next message and only holds back its final encryption. A two-entry queue
// keeps accepting words while the back end works, until it is full. Reset clears the
// control state and the configuration, chaining and header registers, but not the
// subkey, tag or queue storage registers.
module eps_integrity_cmac_tag (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        valid,
	output logic        stall,
	input  logic [63:0] data_word,
	input  logic [6:0]  valid_bits,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] mac
);
	logic [63:0] kh_q, kl_q;
	logic [31:0] cnt_q;
	logic [4:0]  bearer_q;
	logic        dir_q;
	logic        q_valid, q_pop;
	eia2_pkg::item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kh_q <= '0; kl_q <= '0; cnt_q <= '0; bearer_q <= '0; dir_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				eia2_pkg::RegKeyHigh: kh_q <= cfg_data;
				eia2_pkg::RegKeyLow:  kl_q <= cfg_data;
				eia2_pkg::RegCount:   cnt_q <= cfg_data[31:0];
				eia2_pkg::RegBearer:  bearer_q <= cfg_data[4:0];
				eia2_pkg::RegDir:     dir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	eia2_front u_front (.clk, .arst_n, .valid, .stall, .data_word, .valid_bits,
		.last_word, .q_valid, .q_item, .q_pop);

	eia2_back u_back (.clk, .arst_n, .key({kh_q, kl_q}), .cnt_reg(cnt_q),
		.bearer_reg(bearer_q), .dir_reg(dir_q), .q_valid, .q_item, .q_pop,
		.out_valid, .out_stall, .mac);
endmodule

FILE: rtl/eia2_front.sv
// Front end: takes input items, saturates the bit count and queues them.
module eia2_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 stall,
	input  logic [63:0]          data_word,
	input  logic [6:0]           valid_bits,
	input  logic                 last_word,
	output logic                 q_valid,
	output eia2_pkg::item_t      q_item,
	input  logic                 q_pop
);
	eia2_pkg::item_t mem_q [2];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       push;
	eia2_pkg::item_t it;

	assign stall = (cnt_q == 2'd2);
	assign push = valid && !stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rd_q];

	always_comb begin
		it.word = data_word;
		it.last = last_word;
		// Non-last words always carry a full word.
		if (!last_word || valid_bits > 7'd64)
			it.nbits = 7'd64;
		else
			it.nbits = valid_bits;
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= it;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

FILE: rtl/eia2_aes.sv
// Iterative AES-128 encryptor: one round and one key expansion step per cycle.
module eia2_aes (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] key,
	input  logic [127:0] din,
	output logic         done,
	output logic [127:0] dout
);
	logic [3:0]   round_q;
	logic         busy_q;
	logic [127:0] st_q, rk_q;
	logic [127:0] rk_n;
	logic [7:0]   rc_q;

	assign rk_n = eia2_pkg::key_next(rk_q, rc_q);
	assign dout = st_q;

	always_ff @(posedge clk) begin
		if (start) begin
			st_q <= din ^ key;
			rk_q <= key;
			rc_q <= 8'h01;
		end else if (busy_q) begin
			st_q <= eia2_pkg::aes_round(st_q, rk_n, round_q == 4'd10);
			rk_q <= rk_n;
			rc_q <= eia2_pkg::xtime(rc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			round_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				round_q <= 4'd1;
			end else if (busy_q) begin
				round_q <= round_q + 4'd1;
				if (round_q == 4'd10) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

FILE: rtl/eia2_back.sv
// Back end: header, subkeys, block assembly, CBC chaining and tag output.
module eia2_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [127:0]      key,
	input  logic [31:0]       cnt_reg,
	input  logic [4:0]        bearer_reg,
	input  logic              dir_reg,
	input  logic              q_valid,
	input  eia2_pkg::item_t   q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       mac
);
	eia2_pkg::state_t state_q, state_n;
	logic [127:0] k1_q, k2_q, chain_q, pend_q;
	logic [7:0]   pbits_q;
	logic         hdr_q;
	logic [31:0]  mac_q;
	logic         ov_q;
	logic         aes_start, aes_done;
	logic [127:0] aes_din, aes_dout;
	logic [127:0] pend_ins, fin_blk, word_mask, word_sh;
	logic [7:0]   nb8;
	logic         do_take;

	eia2_aes u_aes (.clk, .arst_n, .start(aes_start), .key, .din(aes_din),
		.done(aes_done), .dout(aes_dout));

	assign out_valid = ov_q;
	assign mac = mac_q;
	assign nb8 = {1'b0, q_item.nbits};

	// Bits fill pend from the top; pbits_q is 0 or 64 whenever a nonempty word is taken, so a word fits.
	always_comb begin
		word_mask = ~(128'h0) << (8'd128 - nb8);
		if (q_item.nbits == 7'd0)
			word_mask = '0;
		word_sh = ({q_item.word, 64'd0} & word_mask) >> pbits_q;
		pend_ins = pend_q | word_sh;
		if (pbits_q + nb8 >= 8'd128)
			fin_blk = pend_ins ^ k1_q;
		else
			fin_blk = (pend_ins | (128'h8000_0000_0000_0000_0000_0000_0000_0000
				>> (pbits_q + nb8))) ^ k2_q;
	end

	always_comb begin
		state_n = state_q;
		aes_start = 1'b0;
		aes_din = '0;
		q_pop = 1'b0;
		do_take = 1'b0;
		case (state_q)
			eia2_pkg::ST_IDLE: begin
				if (q_valid) begin
					if (!hdr_q) begin
						aes_start = 1'b1;
						state_n = eia2_pkg::ST_SUBKEY;
					end else if (pbits_q == 8'd128 &&
							!(q_item.last && q_item.nbits == 7'd0)) begin
						// A full block is absorbed only once more bits follow.
						aes_start = 1'b1;
						aes_din = chain_q ^ pend_q;
						state_n = eia2_pkg::ST_ABSORB;
					end else if (!q_item.last || !ov_q || !out_stall) begin
						// A final encryption waits until the previous tag is leaving.
						q_pop = 1'b1;
						do_take = 1'b1;
						if (q_item.last) begin
							aes_start = 1'b1;
							aes_din = chain_q ^ fin_blk;
							state_n = eia2_pkg::ST_FINAL;
						end
					end
				end
			end
			eia2_pkg::ST_SUBKEY, eia2_pkg::ST_ABSORB: begin
				if (aes_done)
					state_n = eia2_pkg::ST_IDLE;
			end
			eia2_pkg::ST_FINAL: begin
				if (aes_done)
					state_n = eia2_pkg::ST_IDLE;
			end
			default: state_n = eia2_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == eia2_pkg::ST_SUBKEY && aes_done) begin
			k1_q <= eia2_pkg::dbl(aes_dout);
			k2_q <= eia2_pkg::dbl(eia2_pkg::dbl(aes_dout));
		end
		if (state_q == eia2_pkg::ST_FINAL && aes_done)
			mac_q <= aes_dout[127:96];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eia2_pkg::ST_IDLE;
			chain_q <= '0;
			pend_q <= '0;
			pbits_q <= '0;
			hdr_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ov_q && !out_stall)
				ov_q <= 1'b0;
			if (state_q == eia2_pkg::ST_IDLE && q_valid && !hdr_q) begin
				chain_q <= '0;
				pend_q <= {cnt_reg, bearer_reg, dir_reg, 2'b00, 88'd0};
				pbits_q <= 8'd64;
				hdr_q <= 1'b1;
			end
			if (state_q == eia2_pkg::ST_ABSORB && aes_done) begin
				chain_q <= aes_dout;
				pend_q <= '0;
				pbits_q <= '0;
			end
			if (do_take) begin
				if (q_item.last) begin
					pend_q <= '0;
					pbits_q <= '0;
					hdr_q <= 1'b0;
				end else begin
					pend_q <= pend_ins;
					pbits_q <= pbits_q + 8'd64;
				end
			end
			if (state_q == eia2_pkg::ST_FINAL && aes_done)
				ov_q <= 1'b1;
		end
	end
endmodule

FILE: bench/eps_integrity_cmac_tag_checker.sv
// Checker for the EIA2 tag block: predicts each tag and compares it with the block's output.
`timescale 1ns / 100ps
module eps_integrity_cmac_tag_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        valid,
	input  logic        stall,
	input  logic [63:0] data_word,
	input  logic [6:0]  valid_bits,
	input  logic        last_word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] mac,
	output int          bad_count,
	output int          tags_owed,
	output int          tags_checked
);

	logic [7:0]   sub_tab [256];
	logic [63:0]  key_hi, key_lo;
	logic [31:0]  count_reg;
	logic [4:0]   bearer_reg;
	logic         dir_reg;
	logic [127:0] sk_one, sk_two, chain, held;
	int           held_bits;
	logic         in_msg;
	logic [31:0]  tag_q [$];

	function automatic logic [7:0] gf_x2(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p = p ^ a;
			a = gf_x2(a);
		end
		return p;
	endfunction

	// The S-box is built from the field inverse and the affine map.
	initial begin
		logic [7:0] inv, s;
		for (int a = 0; a < 256; a++) begin
			inv = 8'h00;
			for (int b = 1; b < 256; b++)
				if (gf_mul(a[7:0], b[7:0]) == 8'h01)
					inv = b[7:0];
			s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			sub_tab[a] = s;
		end
	end

	function automatic logic [127:0] aes128(input logic [127:0] blk, input logic [127:0] key);
		logic [31:0] w [44];
		logic [31:0] tmp;
		logic [7:0]  rc;
		logic [7:0]  b [16];
		logic [7:0]  t [16];
		logic [7:0]  a0, a1, a2, a3;
		logic [127:0] rk;
		rc = 8'h01;
		for (int i = 0; i < 4; i++)
			w[i] = key[127-32*i -: 32];
		for (int i = 4; i < 44; i++) begin
			tmp = w[i-1];
			if (i % 4 == 0) begin
				tmp = {sub_tab[tmp[23:16]] ^ rc, sub_tab[tmp[15:8]], sub_tab[tmp[7:0]],
					sub_tab[tmp[31:24]]};
				rc = gf_x2(rc);
			end
			w[i] = w[i-4] ^ tmp;
		end
		blk = blk ^ key;
		for (int r = 1; r <= 10; r++) begin
			for (int i = 0; i < 16; i++)
				b[i] = sub_tab[blk[127-8*i -: 8]];
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[4*c+i] = b[4*((c+i)%4)+i];
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					t[4*c]   = gf_x2(a0) ^ gf_x2(a1) ^ a1 ^ a2 ^ a3;
					t[4*c+1] = a0 ^ gf_x2(a1) ^ gf_x2(a2) ^ a2 ^ a3;
					t[4*c+2] = a0 ^ a1 ^ gf_x2(a2) ^ gf_x2(a3) ^ a3;
					t[4*c+3] = gf_x2(a0) ^ a0 ^ a1 ^ a2 ^ gf_x2(a3);
				end
			end
			rk = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
			for (int i = 0; i < 16; i++)
				blk[127-8*i -: 8] = t[i];
			blk = blk ^ rk;
		end
		return blk;
	endfunction

	function automatic logic [127:0] gf_double(input logic [127:0] v);
		return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? eia2_pkg::CmacRb : 8'h00)};
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: tag error (%s): got %08h, expected %08h", $time, what, got, want);
		bad_count++;
	endtask

	// Works out the tag, if any, that one accepted item causes.
	task automatic tag_predict(input logic [63:0] w, input logic [6:0] vb, input logic lst);
		logic [127:0] k;
		int n;
		k = {key_hi, key_lo};
		if (!in_msg) begin
			sk_one = gf_double(aes128(128'd0, k));
			sk_two = gf_double(sk_one);
			chain = '0;
			held = {count_reg, bearer_reg, dir_reg, 2'b00, 88'd0};
			held_bits = eia2_pkg::WordBits;
			in_msg = 1'b1;
		end
		n = !lst ? eia2_pkg::WordBits
			: (vb > eia2_pkg::WordBits ? eia2_pkg::WordBits : vb);
		for (int i = 0; i < n; i++) begin
			if (held_bits >= 128) begin
				chain = aes128(chain ^ held, k);
				held = '0;
				held_bits = 0;
			end
			held[127-held_bits] = w[eia2_pkg::WordBits-1-i];
			held_bits++;
		end
		if (lst) begin
			if (held_bits >= 128) begin
				chain = aes128(chain ^ held ^ sk_one, k);
			end else begin
				held[127-held_bits] = 1'b1;
				chain = aes128(chain ^ held ^ sk_two, k);
			end
			tag_q.push_back(chain[127:96]);
			held = '0;
			held_bits = 0;
			in_msg = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi = '0; key_lo = '0; count_reg = '0; bearer_reg = '0; dir_reg = 1'b0;
			sk_one = '0; sk_two = '0; chain = '0; held = '0;
			held_bits = 0;
			in_msg = 1'b0;
			bad_count = 0;
			tags_checked = 0;
			tag_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (tag_q.size() == 0) begin
					report("no tag expected", mac, 32'h0);
				end else begin
					if (mac !== tag_q[0])
						report("mac", mac, tag_q[0]);
					void'(tag_q.pop_front());
					tags_checked++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				eia2_pkg::RegKeyHigh: key_hi = cfg_data;
				eia2_pkg::RegKeyLow:  key_lo = cfg_data;
				eia2_pkg::RegCount:   count_reg = cfg_data[31:0];
				eia2_pkg::RegBearer:  bearer_reg = cfg_data[4:0];
				eia2_pkg::RegDir:     dir_reg = cfg_data[0];
				default: ;
				endcase
			end
			if (valid && !stall)
				tag_predict(data_word, valid_bits, last_word);
		end
		tags_owed = tag_q.size();
	end

endmodule

FILE: bench/tb_eps_integrity_cmac_tag.sv
// Testbench top for the EIA2 tag block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_eps_integrity_cmac_tag;

	localparam int CycleLimit = 500000;
	localparam int DrainCycles = 40;

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        valid, stall;
	logic [63:0] data_word;
	logic [6:0]  valid_bits;
	logic        last_word;
	logic        out_valid, out_stall;
	logic [31:0] mac;
	int          bad_count, tags_owed, tags_checked;
	int          words_sent, msgs_sent, cycles;
	bit          burst, long_hold_done;

	eps_integrity_cmac_tag DUT (.*);

	eps_integrity_cmac_tag_checker checker_i (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .valid, .stall,
		.data_word, .valid_bits, .last_word, .out_valid, .out_stall, .mac,
		.bad_count, .tags_owed, .tags_checked
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("eps_integrity_cmac_tag: mismatch");
			$finish;
		end
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] v);
		bit hit;
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do begin
			@(negedge clk); hit = cfg_ready;
			@(posedge clk);
		end while (!hit);
		cfg_valid <= 1'b0;
	endtask

	// valid stays high between items when no gap is drawn.
	task automatic send_word(input logic [63:0] w, input logic [6:0] vb, input logic lst);
		int gap;
		bit hit;
		gap = burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_word <= w;
		valid_bits <= vb;
		last_word <= lst;
		valid <= 1'b1;
		do begin
			@(negedge clk); hit = !stall;
			@(posedge clk);
		end while (!hit);
		words_sent++;
		if (lst)
			msgs_sent++;
	endtask

	task automatic send_msg(input int nwords, input logic [6:0] last_bits);
		burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < nwords - 1; i++)
			send_word(rand_word(), 7'($urandom_range(0, 127)), 1'b0);
		send_word(rand_word(), last_bits, 1'b1);
	endtask

	// Lets every tag come out and the block go idle before the next register write.
	task automatic settle();
		valid <= 1'b0;
		@(posedge clk);
		while (tags_owed != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic load_regs(input int mode);
		logic [63:0] v [5];
		for (int i = 0; i < 5; i++)
			v[i] = (mode == 1) ? '1 : (mode == 2) ? '0 : rand_word();
		cfg_write(eia2_pkg::RegKeyHigh, v[0]);
		cfg_write(eia2_pkg::RegKeyLow, v[1]);
		cfg_write(eia2_pkg::RegCount, v[2]);
		cfg_write(eia2_pkg::RegBearer, v[3]);
		cfg_write(eia2_pkg::RegDir, v[4]);
		// An index past the register list must be ignored.
		cfg_write(3'($urandom_range(eia2_pkg::RegDir + 1, 3'h7)), rand_word());
	endtask

	// Receiver: random stall per tag, plus one long hold-off while words keep coming.
	initial begin
		int n;
		bit hit;
		out_stall <= 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && words_sent >= 300) begin
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end
			n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk); hit = out_valid;
				@(posedge clk);
			end while (!hit);
		end
	end

	initial begin
		int nw;
		logic [6:0] lb;
		words_sent = 0;
		msgs_sent = 0;
		burst = 1'b0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= eia2_pkg::RegKeyHigh;
		cfg_data <= '0;
		valid <= 1'b0;
		data_word <= '0;
		valid_bits <= '0;
		last_word <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed messages with the registers at their reset values.
		send_word('1, 7'd0, 1'b1);                    // empty message: header only
		send_word('1, 7'd64, 1'b1);                   // exactly one full block
		send_word(64'hAAAA_5555_AAAA_5555, 7'd127, 1'b1); // too many valid bits
		send_word(64'h8000_0000_0000_0000, 7'd1, 1'b1);
		send_word(rand_word(), 7'd63, 1'b1);
		send_word('1, 7'd0, 1'b0);                    // valid_bits ignored on non-last
		send_word('0, 7'd0, 1'b1);
		send_word(rand_word(), 7'd127, 1'b0);
		send_word(rand_word(), 7'd5, 1'b0);
		send_word('1, 7'd64, 1'b1);                   // two full blocks
		send_word('0, 7'd65, 1'b1);
		send_word(rand_word(), 7'd127, 1'b0);
		send_word(rand_word(), 7'd32, 1'b1);
		settle();

		for (int p = 0; p < 10; p++) begin
			load_regs(p == 0 ? 1 : p == 1 ? 2 : 0);
			if (p == 0) begin
				send_word('1, 7'd64, 1'b1);
				send_word('1, 7'd0, 1'b1);
			end
			repeat (30) begin
				nw = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 24)
					: $urandom_range(1, 5);
				case ($urandom_range(0, 3))
				0: lb = 7'd0;
				1: lb = 7'd64;
				default: lb = 7'($urandom_range(0, 127));
				endcase
				send_msg(nw, lb);
			end
			settle();
		end

		$display("sent %0d words in %0d messages over 11 register settings", words_sent,
			msgs_sent);
		$display("checked %0d tags, %0d errors", tags_checked, bad_count);
		if (bad_count == 0 && tags_owed == 0)
			$display("eps_integrity_cmac_tag: match");
		else
			$display("eps_integrity_cmac_tag: mismatch");
		$finish;
	end

endmodule

FILE: files.f
rtl/eia2_pkg.sv
rtl/eia2_front.sv
rtl/eia2_aes.sv
rtl/eia2_back.sv
rtl/eps_integrity_cmac_tag.sv
bench/eps_integrity_cmac_tag_checker.sv
bench/tb_eps_integrity_cmac_tag.sv
